### design/rqci_pkg.sv
// Shared constants, register indexes and the quadrant visit order table.
package rqci_pkg;

	// Direction components are signed Q1.16 in 18 bits
	localparam int DIR_W     = 18;
	localparam int FRAC_BITS = 16;
	// Quotient bits resolved per divider stage
	localparam int DIV_STEP  = 4;

	// Configuration register indexes
	localparam logic [1:0] REG_BOX_LEFT   = 2'd0;
	localparam logic [1:0] REG_BOX_TOP    = 2'd1;
	localparam logic [1:0] REG_BOX_WIDTH  = 2'd2;
	localparam logic [1:0] REG_BOX_HEIGHT = 2'd3;

	// Visit order: row is {dz >= 0, dx >= 0}, column is the position in the run
	localparam logic [1:0] ORDER_TAB [4][4] = '{
		'{2'd1, 2'd0, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd3, 2'd2},
		'{2'd2, 2'd3, 2'd1, 2'd0},
		'{2'd3, 2'd2, 2'd0, 2'd1}
	};

	function automatic logic [1:0] quad_order(input logic [1:0] dir_idx, input logic [1:0] pos);
		return ORDER_TAB[dir_idx][pos];
	endfunction

endpackage

### design/ray_quadtree_child_intervals.sv
// Ray slab test against a quadtree node box, split into four child quadrant intervals.
// The output port issues one result per cycle while m_axis_tready is high; each ray yields four results,
// and the pipeline and input stall while a ray waits in the last stage for the serializer.
// The six divisions run in a pipelined restoring divider resolving four quotient bits per stage.
// Reset (arst_n low) clears all valid bits and loads the box registers with their defaults.
module ray_quadtree_child_intervals
	import rqci_pkg::*;
#(
	parameter int COORD_WIDTH = 18,
	parameter int T_WIDTH     = 24
) (
	input  logic clk,
	input  logic arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_addr,
	input  logic [COORD_WIDTH-1:0] cfg_wdata,
	// tdata: origin_x, origin_z, dir_x, dir_z, ray_length, zero pad
	input  logic                                             s_axis_tvalid,
	output logic                                             s_axis_tready,
	input  logic [((3*COORD_WIDTH+2*DIR_W+7)/8)*8-1:0]       s_axis_tdata,
	// tdata: t_enter, t_exit, crossed, root_hit, zero pad
	output logic                                             m_axis_tvalid,
	input  logic                                             m_axis_tready,
	output logic [((2*T_WIDTH+2+7)/8)*8-1:0]                 m_axis_tdata,
	output logic                                             m_axis_tlast,
	// tuser: quadrant
	output logic [1:0]                                       m_axis_tuser
);

	localparam int CW    = COORD_WIDTH;
	localparam int TW    = T_WIDTH;
	localparam int NW    = CW + 2;
	localparam int NB    = NW + FRAC_BITS;
	localparam int NST   = (NB + DIV_STEP - 1) / DIV_STEP;
	localparam int MW    = ((NB > TW) ? NB : TW) + 1;
	localparam int CMPW  = ((CW > TW) ? CW : TW) + 2;
	localparam int OUT_W = ((2*TW + 2 + 7) / 8) * 8;

	localparam logic signed [TW-1:0] TMAX = {1'b0, {(TW-1){1'b1}}};
	localparam logic signed [TW-1:0] TMIN = {1'b1, {(TW-1){1'b0}}};
	localparam logic [MW-1:0] MAGP = MW'(TMAX);
	localparam logic [MW-1:0] MAGN = MAGP + MW'(1);

	typedef struct packed {
		logic          miss;
		logic          dxz;
		logic          dzz;
		logic          dxneg;
		logic          dzneg;
		logic          cxa;
		logic          cza;
		logic [CW-1:0] len;
		logic [5:0]    neg;
	} side_t;

	typedef struct packed {
		logic [1:0]           quad;
		logic signed [TW-1:0] te;
		logic signed [TW-1:0] tx;
		logic                 cr;
	} res_t;

	logic adv;

	// ---------------- configuration registers ----------------
	logic signed [CW-1:0] box_left_q, box_top_q;
	logic [CW-2:0]        box_width_q, box_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= CW'(16384);
			box_top_q    <= CW'(16384);
			box_width_q  <= (CW-1)'(32768);
			box_height_q <= (CW-1)'(32768);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BOX_LEFT:   box_left_q   <= cfg_wdata;
				REG_BOX_TOP:    box_top_q    <= cfg_wdata;
				REG_BOX_WIDTH:  box_width_q  <= cfg_wdata[CW-2:0];
				REG_BOX_HEIGHT: box_height_q <= cfg_wdata[CW-2:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: input capture ----------------
	logic                    v_s1;
	logic signed [CW-1:0]    px_s1, pz_s1;
	logic signed [DIR_W-1:0] dx_s1, dz_s1;
	logic [CW-1:0]           len_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1  <= s_axis_tdata[CW-1:0];
			pz_s1  <= s_axis_tdata[2*CW-1:CW];
			dx_s1  <= s_axis_tdata[2*CW+DIR_W-1:2*CW];
			dz_s1  <= s_axis_tdata[2*CW+2*DIR_W-1:2*CW+DIR_W];
			len_s1 <= s_axis_tdata[3*CW+2*DIR_W-1:2*CW+2*DIR_W];
		end
	end

	// ---------------- stage 2: plane distances, divider setup ----------------
	logic signed [NW-1:0] n_c [0:5];
	logic [NW-1:0]        nm_c [0:5];
	logic [DIR_W-1:0]     dmx_c, dmz_c;
	side_t                side_c;

	always_comb begin
		logic signed [NW-1:0] lft, rgt, cx, top, bot, cz, px, pz;
		lft = NW'(box_left_q);
		rgt = lft + NW'({1'b0, box_width_q});
		cx  = lft + NW'({2'b0, box_width_q[CW-2:1]});
		top = NW'(box_top_q);
		bot = top + NW'({1'b0, box_height_q});
		cz  = top + NW'({2'b0, box_height_q[CW-2:1]});
		px  = NW'(px_s1);
		pz  = NW'(pz_s1);
		n_c[0] = lft - px;
		n_c[1] = rgt - px;
		n_c[2] = cx - px;
		n_c[3] = top - pz;
		n_c[4] = bot - pz;
		n_c[5] = cz - pz;
		for (int l = 0; l < 6; l++)
			nm_c[l] = n_c[l][NW-1] ? NW'(-n_c[l]) : n_c[l];
		dmx_c = dx_s1[DIR_W-1] ? DIR_W'(-dx_s1) : dx_s1;
		dmz_c = dz_s1[DIR_W-1] ? DIR_W'(-dz_s1) : dz_s1;
		side_c.dxz   = (dx_s1 == '0);
		side_c.dzz   = (dz_s1 == '0);
		side_c.dxneg = dx_s1[DIR_W-1];
		side_c.dzneg = dz_s1[DIR_W-1];
		side_c.cxa   = (n_c[2] > 0);
		side_c.cza   = (n_c[5] > 0);
		side_c.len   = len_s1;
		side_c.miss  = (side_c.dxz && side_c.dzz)
			|| (side_c.dxz && (px < lft || px > rgt))
			|| (side_c.dzz && (pz < top || pz > bot));
		for (int l = 0; l < 6; l++)
			side_c.neg[l] = n_c[l][NW-1] ^ ((l < 3) ? dx_s1[DIR_W-1] : dz_s1[DIR_W-1]);
		// a zero divisor only feeds lanes whose quotient is ignored
		if (dmx_c == '0) dmx_c = DIR_W'(1);
		if (dmz_c == '0) dmz_c = DIR_W'(1);
	end

	// divider stage registers, index 0 is stage 2
	logic [NB-1:0]    div_acc_s [0:NST][0:5];
	logic [DIR_W-1:0] div_rem_s [0:NST][0:5];
	logic [DIR_W-1:0] div_dm_s  [0:NST][0:1];
	side_t            div_side_s [0:NST];
	logic             div_v_s   [0:NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_v_s[0] <= 1'b0;
		else if (adv) div_v_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 6; l++) begin
				div_acc_s[0][l] <= {nm_c[l], {FRAC_BITS{1'b0}}};
				div_rem_s[0][l] <= '0;
			end
			div_dm_s[0][0] <= dmx_c;
			div_dm_s[0][1] <= dmz_c;
			div_side_s[0]  <= side_c;
		end
	end

	// ---------------- restoring divider, DIV_STEP bits per stage ----------------
	for (genvar g = 1; g <= NST; g++) begin : g_div
		logic [NB-1:0]    nacc [0:5];
		logic [DIR_W-1:0] nrem [0:5];

		always_comb begin
			logic [NB-1:0]    a;
			logic [DIR_W-1:0] r;
			logic [DIR_W:0]   tr;
			logic [DIR_W-1:0] dd;
			for (int l = 0; l < 6; l++) begin
				a  = div_acc_s[g-1][l];
				r  = div_rem_s[g-1][l];
				dd = div_dm_s[g-1][l >= 3];
				for (int j = 0; j < DIV_STEP; j++) begin
					if ((g-1)*DIV_STEP + j < NB) begin
						tr = {r, a[NB-1]};
						if (tr >= {1'b0, dd}) begin
							tr = tr - {1'b0, dd};
							a  = {a[NB-2:0], 1'b1};
						end else begin
							a  = {a[NB-2:0], 1'b0};
						end
						r = tr[DIR_W-1:0];
					end
				end
				nacc[l] = a;
				nrem[l] = r;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_v_s[g] <= 1'b0;
			else if (adv) div_v_s[g] <= div_v_s[g-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 6; l++) begin
					div_acc_s[g][l] <= nacc[l];
					div_rem_s[g][l] <= nrem[l];
				end
				div_dm_s[g]   <= div_dm_s[g-1];
				div_side_s[g] <= div_side_s[g-1];
			end
		end
	end

	// ---------------- stage 3: sign and saturate quotients ----------------
	logic signed [TW-1:0] q_c [0:5];

	always_comb begin
		logic [MW-1:0] m, ng;
		for (int l = 0; l < 6; l++) begin
			m  = MW'(div_acc_s[NST][l]);
			ng = ~m + MW'(1);
			if (!div_side_s[NST].neg[l]) q_c[l] = (m > MAGP) ? TMAX : m[TW-1:0];
			else                          q_c[l] = (m > MAGN) ? TMIN : ng[TW-1:0];
		end
		// centre line parallel to the ray
		if (div_side_s[NST].dxz) q_c[2] = div_side_s[NST].cxa ? TMAX : TMIN;
		if (div_side_s[NST].dzz) q_c[5] = div_side_s[NST].cza ? TMAX : TMIN;
	end

	logic                 v_s3;
	logic signed [TW-1:0] t_s3 [0:5];
	side_t                side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= div_v_s[NST];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 6; l++) t_s3[l] <= q_c[l];
			side_s3 <= div_side_s[NST];
		end
	end

	// ---------------- stage 4: combine slabs ----------------
	logic signed [TW-1:0] ent_c, ext_c;

	always_comb begin
		logic signed [TW-1:0] xe, xx, ze, zx;
		xe = side_s3.dxz ? TMIN : ((t_s3[0] < t_s3[1]) ? t_s3[0] : t_s3[1]);
		xx = side_s3.dxz ? TMAX : ((t_s3[0] > t_s3[1]) ? t_s3[0] : t_s3[1]);
		ze = side_s3.dzz ? TMIN : ((t_s3[3] < t_s3[4]) ? t_s3[3] : t_s3[4]);
		zx = side_s3.dzz ? TMAX : ((t_s3[3] > t_s3[4]) ? t_s3[3] : t_s3[4]);
		ent_c = (xe > ze) ? xe : ze;
		ext_c = (xx < zx) ? xx : zx;
	end

	logic                 v_s4;
	logic signed [TW-1:0] ent_s4, ext_s4, tx_s4, tz_s4;
	side_t                side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s4  <= ent_c;
			ext_s4  <= ext_c;
			tx_s4   <= t_s3[2];
			tz_s4   <= t_s3[5];
			side_s4 <= side_s3;
		end
	end

	// ---------------- stage 5: clip to [0, length] ----------------
	logic signed [TW-1:0] entc_c, extc_c;
	logic                 hit_c;

	always_comb begin
		logic signed [CMPW-1:0] ew, lw;
		ew     = CMPW'(ext_s4);
		lw     = signed'({{(CMPW-CW){1'b0}}, side_s4.len});
		entc_c = ent_s4[TW-1] ? '0 : ent_s4;
		extc_c = (ew > lw) ? TW'(side_s4.len) : ext_s4;
		hit_c  = !side_s4.miss && (ent_s4 <= ext_s4) && (entc_c <= extc_c);
	end

	logic                 v_s5, hit_s5;
	logic signed [TW-1:0] ent_s5, ext_s5, tx_s5, tz_s5;
	logic [1:0]           dir_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s5 <= entc_c;
			ext_s5 <= extc_c;
			hit_s5 <= hit_c;
			tx_s5  <= tx_s4;
			tz_s5  <= tz_s4;
			dir_s5 <= {!side_s4.dzneg, !side_s4.dxneg};
		end
	end

	// ---------------- stage 6: quadrant intervals ----------------
	res_t res_c [0:3];

	always_comb begin
		logic signed [TW-1:0] fr [0:3];
		logic signed [TW-1:0] to [0:3];
		logic signed [TW-1:0] mnxz, mxxz;
		mnxz  = (tx_s5 < tz_s5) ? tx_s5 : tz_s5;
		mxxz  = (tx_s5 > tz_s5) ? tx_s5 : tz_s5;
		fr[0] = ent_s5;
		to[0] = (mnxz < ext_s5) ? mnxz : ext_s5;
		fr[1] = (tx_s5 > ent_s5) ? tx_s5 : ent_s5;
		to[1] = (tz_s5 < ext_s5) ? tz_s5 : ext_s5;
		fr[2] = (tz_s5 > ent_s5) ? tz_s5 : ent_s5;
		to[2] = (tx_s5 < ext_s5) ? tx_s5 : ext_s5;
		fr[3] = (mxxz > ent_s5) ? mxxz : ent_s5;
		to[3] = ext_s5;
		for (int k = 0; k < 4; k++) begin
			res_c[k].quad = quad_order(dir_s5, 2'(k));
			res_c[k].te   = hit_s5 ? fr[k] : '0;
			res_c[k].tx   = hit_s5 ? to[k] : '0;
			res_c[k].cr   = hit_s5 && (fr[k] <= to[k]);
		end
	end

	logic v_s6, hit_s6;
	res_t res_s6 [0:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) res_s6[k] <= res_c[k];
			hit_s6 <= hit_s5;
		end
	end

	// ---------------- output serializer: four transfers per ray ----------------
	logic       busy_q, hit_q;
	logic [1:0] cnt_q;
	res_t       res_q [0:3];
	logic       take;

	assign take = !busy_q || (cnt_q == 2'd3 && m_axis_tready);
	assign adv  = !v_s6 || take;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (take) begin
			busy_q <= v_s6;
			cnt_q  <= '0;
		end else if (m_axis_tready) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && v_s6) begin
			for (int k = 0; k < 4; k++) res_q[k] <= res_s6[k];
			hit_q <= hit_s6;
		end
	end

	assign m_axis_tvalid = busy_q;
	assign m_axis_tlast  = (cnt_q == 2'd3);
	assign m_axis_tuser  = res_q[cnt_q].quad;
	assign m_axis_tdata  = OUT_W'({hit_q, res_q[cnt_q].cr, res_q[cnt_q].tx, res_q[cnt_q].te});

	// ---------------- assertions ----------------
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("ray run ended before its fourth result");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[2*TW+1]) |-> (!m_axis_tdata[2*TW] && m_axis_tdata[TW-1:0] == '0))
		else $error("missed ray reports a crossing or nonzero t");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !adv) |=> v_s6)
		else $error("stalled ray dropped from the last stage");

endmodule

### tb/rqci_checker.sv
// Checker: predicts the four child quadrant intervals of each ray and compares them.
module rqci_checker
	import rqci_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [17:0] cfg_wdata,
	input  logic        s_valid,
	input  logic        s_ready,
	input  logic [95:0] s_data,
	input  logic        m_valid,
	input  logic        m_ready,
	input  logic [55:0] m_data,
	input  logic        m_last,
	input  logic [1:0]  m_user,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [1:0]  quadrant;
		logic [23:0] t_enter;
		logic [23:0] t_exit;
		logic        crossed;
		logic        root_hit;
		logic        last;
	} quad_result_t;

	localparam longint T_HI = 64'sd8388607;
	localparam longint T_LO = -64'sd8388608;

	quad_result_t quad_q[$];
	logic signed [17:0] left_r, top_r;
	logic [16:0] width_r, height_r;

	function automatic longint clamp_t(longint v);
		if (v > T_HI) return T_HI;
		if (v < T_LO) return T_LO;
		return v;
	endfunction

	// Quotient in Q.16, truncated toward zero
	function automatic longint fx_div(longint num, longint d);
		return clamp_t((num * 65536) / d);
	endfunction

	function automatic longint lmin(longint a, longint b);
		return a < b ? a : b;
	endfunction

	function automatic longint lmax(longint a, longint b);
		return a > b ? a : b;
	endfunction

	// Work out the four results of one ray
	task automatic predict_quadrants(input logic [95:0] d);
		longint px, pz, dx, dz, len, lft, tp, w, h, ent, ext, tx, tz, a, b, cx, cz;
		longint from_t[4], to_t[4];
		logic hit;
		logic [1:0] row;
		quad_result_t r;
		px = longint'($signed(d[17:0]));
		pz = longint'($signed(d[35:18]));
		dx = longint'($signed(d[53:36]));
		dz = longint'($signed(d[71:54]));
		len = longint'({1'b0, d[89:72]});
		lft = longint'(left_r);
		tp = longint'(top_r);
		w = longint'({1'b0, width_r});
		h = longint'({1'b0, height_r});
		ent = T_LO;
		ext = T_HI;
		hit = !(dx == 0 && dz == 0);
		// x slab
		if (dx == 0) begin
			if (px < lft || px > lft + w) hit = 0;
		end else begin
			a = fx_div(lft - px, dx);
			b = fx_div(lft + w - px, dx);
			ent = lmax(ent, lmin(a, b));
			ext = lmin(ext, lmax(a, b));
		end
		// z slab
		if (dz == 0) begin
			if (pz < tp || pz > tp + h) hit = 0;
		end else begin
			a = fx_div(tp - pz, dz);
			b = fx_div(tp + h - pz, dz);
			ent = lmax(ent, lmin(a, b));
			ext = lmin(ext, lmax(a, b));
		end
		if (hit && ent > ext) hit = 0;
		if (hit) begin
			if (ent < 0) ent = 0;
			if (ext > len) ext = len;
			if (ent > ext) hit = 0;
		end
		cx = lft + w / 2;
		cz = tp + h / 2;
		if (dx == 0) tx = (cx - px > 0) ? T_HI : T_LO;
		else tx = fx_div(cx - px, dx);
		if (dz == 0) tz = (cz - pz > 0) ? T_HI : T_LO;
		else tz = fx_div(cz - pz, dz);
		row = {dz >= 0, dx >= 0};
		from_t[0] = ent;                     to_t[0] = lmin(lmin(tx, tz), ext);
		from_t[1] = lmax(tx, ent);           to_t[1] = lmin(tz, ext);
		from_t[2] = lmax(tz, ent);           to_t[2] = lmin(tx, ext);
		from_t[3] = lmax(lmax(tx, tz), ent); to_t[3] = ext;
		for (int k = 0; k < 4; k++) begin
			r.quadrant = ORDER_TAB[row][k];
			r.t_enter = hit ? from_t[k][23:0] : '0;
			r.t_exit = hit ? to_t[k][23:0] : '0;
			r.crossed = hit && from_t[k] <= to_t[k];
			r.root_hit = hit;
			r.last = (k == 3);
			quad_q.push_back(r);
		end
	endtask

	// Track registers, predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		quad_result_t want;
		if (!arst_n) begin
			left_r <= 18'sd16384;
			top_r <= 18'sd16384;
			width_r <= 17'd32768;
			height_r <= 17'd32768;
			fail_count <= 0;
			quad_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_BOX_LEFT: left_r <= cfg_wdata;
					REG_BOX_TOP: top_r <= cfg_wdata;
					REG_BOX_WIDTH: width_r <= cfg_wdata[16:0];
					REG_BOX_HEIGHT: height_r <= cfg_wdata[16:0];
				endcase
			end
			if (s_valid && s_ready) predict_quadrants(s_data);
			if (m_valid && m_ready) begin
				if (quad_q.size() == 0) begin
					$error("unexpected result transfer quadrant=%0d", m_user);
					fail_count <= fail_count + 1;
				end else begin
					want = quad_q.pop_front();
					if (m_user !== want.quadrant ||
						m_data[23:0] !== want.t_enter ||
						m_data[47:24] !== want.t_exit ||
						m_data[48] !== want.crossed ||
						m_data[49] !== want.root_hit ||
						m_last !== want.last) begin
						if (m_user !== want.quadrant)
							$error("quadrant exp %0d got %0d", want.quadrant, m_user);
						if (m_data[23:0] !== want.t_enter)
							$error("t_enter exp %h got %h", want.t_enter, m_data[23:0]);
						if (m_data[47:24] !== want.t_exit)
							$error("t_exit exp %h got %h", want.t_exit, m_data[47:24]);
						if (m_data[48] !== want.crossed)
							$error("crossed exp %b got %b", want.crossed, m_data[48]);
						if (m_data[49] !== want.root_hit)
							$error("root_hit exp %b got %b", want.root_hit, m_data[49]);
						if (m_last !== want.last)
							$error("last exp %b got %b", want.last, m_last);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign pending = quad_q.size();

endmodule

### tb/tb_ray_quadtree_child_intervals.sv
// Testbench top: drives rays and box settings into the block and gives the verdict.
module tb_ray_quadtree_child_intervals;
	import rqci_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_addr = REG_BOX_LEFT;
	logic [17:0] cfg_wdata = '0;
	logic        s_valid = 0;
	logic        s_ready;
	logic [95:0] s_data = '0;
	logic        m_valid;
	logic        m_ready = 0;
	logic [55:0] m_data;
	logic        m_last;
	logic [1:0]  m_user;
	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	logic        hold_off = 0;
	logic        no_idle = 0;

	ray_quadtree_child_intervals u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
		.m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
		.m_axis_tlast(m_last), .m_axis_tuser(m_user)
	);

	rqci_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
		.m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
		.m_last(m_last), .m_user(m_user),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off on request
	always @(negedge clk) begin
		if (hold_off) m_ready <= 0;
		else if (no_idle) m_ready <= 1;
		else m_ready <= ($urandom_range(99) >= 32);
	end

	task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// Stop offering, wait until all results are out, then let the pipeline drain
	task automatic drain;
		s_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_box(input logic [17:0] l, input logic [17:0] t,
		input logic [16:0] w, input logic [16:0] h);
		drain();
		write_reg(REG_BOX_LEFT, l);
		write_reg(REG_BOX_TOP, t);
		write_reg(REG_BOX_WIDTH, {1'b0, w});
		write_reg(REG_BOX_HEIGHT, {1'b0, h});
	endtask

	// Offer one ray and hold it until transferred; random gaps before it unless no_idle is set
	task automatic send_ray(input logic [17:0] ox, input logic [17:0] oz,
		input logic [17:0] dx, input logic [17:0] dz, input logic [17:0] len);
		if (!no_idle)
			while ($urandom_range(99) < 32) begin
				s_valid <= 0;
				@(negedge clk);
			end
		s_valid <= 1;
		s_data <= {6'b0, len, dz, dx, oz, ox};
		@(posedge clk);
		while (!s_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [17:0] rand_dir();
		int v;
		case ($urandom_range(5))
			0: v = 0;
			1: v = 65536;
			2: v = -65536;
			default: v = $urandom_range(131072) - 65536;
		endcase
		return v[17:0];
	endfunction

	// Rays mostly aimed near the box, some fully random
	task automatic random_ray;
		logic [17:0] ox, oz, len;
		if ($urandom_range(3) == 0) begin
			ox = 18'($urandom);
			oz = 18'($urandom);
		end else begin
			ox = 18'($urandom_range(98304));
			oz = 18'($urandom_range(98304));
		end
		len = ($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(131072));
		send_ray(ox, oz, rand_dir(), rand_dir(), len);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Directed rays at reset box
		send_ray(18'd0, 18'd32768, 18'd65536, 18'd0, 18'h3ffff);
		send_ray(18'd0, 18'd0, 18'd46341, 18'd46341, 18'd131072);
		send_ray(18'd65536, 18'd65536, -18'sd46341, -18'sd46341, 18'd65536);
		send_ray(18'd32768, 18'd16384, 18'd0, 18'd65536, 18'd65536);
		send_ray(18'd32768, 18'd32768, 18'd0, 18'd0, 18'd65536);
		send_ray(18'd0, 18'd0, 18'd65536, 18'd0, 18'd65536);
		send_ray(18'h1ffff, 18'h20000, -18'sd65536, 18'd65536, 18'h3ffff);
		send_ray(18'h20000, 18'h1ffff, 18'd65536, -18'sd65536, 18'd0);
		send_ray(18'd24576, 18'd24576, 18'd1, -18'sd1, 18'h3ffff);
		send_ray(18'd49152, 18'd16384, 18'd0, 18'd65536, 18'd32768);
		send_ray(18'd0, 18'd40000, 18'd65536, 18'd0, 18'd100);
		// Extremes of the box
		set_box(18'h20000, 18'h20000, 17'h1ffff, 17'h1ffff);
		send_ray(18'd0, 18'd0, 18'd46341, -18'sd46341, 18'h3ffff);
		send_ray(18'h20000, 18'h20000, 18'd65536, 18'd65536, 18'h3ffff);
		send_ray(18'h1ffff, 18'h1ffff, -18'sd1, -18'sd65536, 18'h3ffff);
		set_box(18'h1ffff, 18'h1ffff, 17'd0, 17'd0);
		send_ray(18'h1ffff, 18'h1ffff, 18'd0, 18'd65536, 18'h3ffff);
		send_ray(18'd0, 18'd0, 18'd65536, 18'd65536, 18'h3ffff);
		set_box(18'd0, 18'd0, 17'd65536, 17'd65536);
		// Random phase one, no idling stretch included
		for (int i = 0; i < 90; i++) begin
			no_idle = (i >= 30 && i < 60);
			random_ray();
		end
		no_idle = 0;
		// Receiver holds off while the sender keeps offering rays
		drain();
		hold_off = 1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 40; i++) random_ray();
		join
		set_box(18'($urandom), 18'($urandom), 17'($urandom), 17'($urandom));
		for (int i = 0; i < 60; i++) random_ray();
		set_box(18'h3c000, 18'h3c000, 17'd16384, 17'd81920);
		for (int i = 0; i < 50; i++) random_ray();
		drain();
		if (fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
